>>> hw/rtl/sbmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmc_pkg
// Types and constants shared by the shadowed banked memory checker.
// ----------------------------------------------------------------------------
package sbmc_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [2:0]  access_kind;
        logic        is_fetch;
    } in_t;

    typedef struct packed {
        logic       mismatch;
        logic [7:0] expected_byte;
        logic       write_ignored;
        logic       window_strobe;
        logic [2:0] window_reg;
        logic       fail_seen;
    } out_t;

    // what the back end does with a request
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_CHECK,
        ACT_STORE
    } act_t;

    typedef enum logic [2:0] {
        STORE_MAIN,
        STORE_SIDE,
        STORE_SHADOW,
        STORE_OVERLAY,
        STORE_PAGED
    } store_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK
    } back_state_t;

    typedef enum logic {
        REG_MODEL_MASK = 1'b0,
        REG_WINDOW_EN  = 1'b1
    } reg_idx_t;

    // widest cell index (sideways store at the largest bank count)
    localparam int IDX_W = 18;
    localparam int CELL_W = 9;
    localparam int BANK_AW = 14;

    localparam int MAIN_AW       = 16;
    localparam int MAIN_DEPTH    = 65536;
    localparam int SHADOW_AW     = 15;
    localparam int SHADOW_DEPTH  = 20480;
    localparam int OVERLAY_AW    = 13;
    localparam int OVERLAY_DEPTH = 8192;
    localparam int PAGED_AW      = 12;
    localparam int PAGED_DEPTH   = 4096;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [15:0] ADDR_ROM_LATCH = 16'hFE30;
    localparam logic [15:0] ADDR_ACC_LATCH = 16'hFE34;
    localparam logic [7:0]  ROM_LATCH_MASK = 8'h8F;
    localparam logic [15:0] IO_LO          = 16'hFC00;
    localparam logic [15:0] IO_HI          = 16'hFF00;
    localparam logic [15:0] WIN_LO         = 16'hFEE0;
    localparam logic [15:0] WIN_HI         = 16'hFEE8;
    localparam logic [15:0] SHADOW_LO      = 16'h3000;
    localparam logic [15:0] SHADOW_HI      = 16'h8000;
    localparam logic [15:0] PAGED_HI       = 16'h9000;
    localparam logic [15:0] SIDE_HI        = 16'hC000;

    typedef struct packed {
        store_t           store;
        logic [IDX_W-1:0] idx;
    } cell_t;

    typedef struct packed {
        act_t             act;
        store_t           store;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic             write_ignored;
        logic             window_strobe;
        logic [2:0]       window_reg;
    } op_t;

endpackage

>>> hw/rtl/sbmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmc_front
// Accepts bus accesses, tracks the paging latches and the video-driver flag,
// and turns each access into a store request for the back end.
// ----------------------------------------------------------------------------
module sbmc_front #(
    parameter int ROM_BANKS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         model_mask,
    input  logic               window_enable,
    input  logic               in_valid,
    output logic               in_stall,
    input  sbmc_pkg::in_t      in_data,
    input  logic               q_full,
    input  logic               clearing,
    output logic               push,
    output sbmc_pkg::op_t      op
);

    localparam int BANK_W = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;

    logic [7:0]        rom_select_reg;
    logic [7:0]        rom_select_next;
    logic [7:0]        access_control_reg;
    logic [7:0]        access_control_next;
    logic              vdu_flag_reg;
    logic              vdu_flag_next;

    logic [BANK_W-1:0] bank_lut [16];
    logic              modelled;
    logic              io_hole;
    logic              in_overlay;
    logic              fetch_vdu;
    logic [7:0]        rs_eff;
    logic [7:0]        ac_eff;
    logic              vdu_eff;
    logic              writable;
    sbmc_pkg::cell_t   mapped;

    function automatic sbmc_pkg::cell_t map_cell(
        input logic [15:0]       a,
        input logic [7:0]        rs,
        input logic [7:0]        ac,
        input logic              vdu,
        input logic [BANK_W-1:0] bank
    );
        sbmc_pkg::cell_t c;
        logic [15:0]     shadow_off;
        shadow_off = a - sbmc_pkg::SHADOW_LO;
        if (ac[3] && a[15:13] == 3'b110)
        begin
            c.store = sbmc_pkg::STORE_OVERLAY;
            c.idx   = sbmc_pkg::IDX_W'(a[12:0]);
        end
        else if (rs[7] && a[15:12] == 4'h8)
        begin
            c.store = sbmc_pkg::STORE_PAGED;
            c.idx   = sbmc_pkg::IDX_W'(a[11:0]);
        end
        else if (a >= sbmc_pkg::SHADOW_LO && a < sbmc_pkg::SHADOW_HI &&
                 (vdu ? ac[1] : ac[2]))
        begin
            c.store = sbmc_pkg::STORE_SHADOW;
            c.idx   = sbmc_pkg::IDX_W'(shadow_off[sbmc_pkg::SHADOW_AW-1:0]);
        end
        else if (a[15:14] == 2'b10)
        begin
            c.store = sbmc_pkg::STORE_SIDE;
            c.idx   = sbmc_pkg::IDX_W'({bank, a[sbmc_pkg::BANK_AW-1:0]});
        end
        else
        begin
            c.store = sbmc_pkg::STORE_MAIN;
            c.idx   = sbmc_pkg::IDX_W'(a);
        end
        return c;
    endfunction

    // bank number folded into the fitted bank count
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            bank_lut[i] = BANK_W'(i % ROM_BANKS);
        end
    end

    assign in_stall = q_full | clearing;
    assign push     = in_valid & ~in_stall;

    always_comb
    begin
        modelled   = model_mask[in_data.access_kind];
        io_hole    = in_data.address >= sbmc_pkg::IO_LO && in_data.address < sbmc_pkg::IO_HI;
        in_overlay = in_data.address[15:13] == 3'b110;
        fetch_vdu  = ~access_control_reg[3] & in_overlay;

        rs_eff = rom_select_reg;
        ac_eff = access_control_reg;
        if (in_data.func && modelled && in_data.address == sbmc_pkg::ADDR_ROM_LATCH)
        begin
            rs_eff = in_data.data_byte & sbmc_pkg::ROM_LATCH_MASK;
        end
        if (in_data.func && modelled && in_data.address == sbmc_pkg::ADDR_ACC_LATCH)
        begin
            ac_eff = in_data.data_byte;
        end
        vdu_eff = (!in_data.func && in_data.is_fetch) ? fetch_vdu : vdu_flag_reg;

        mapped = map_cell(in_data.address, rs_eff, ac_eff, vdu_eff, bank_lut[rs_eff[3:0]]);

        writable = in_data.address < sbmc_pkg::SHADOW_HI ||
                   (in_data.address < sbmc_pkg::PAGED_HI && rs_eff[7]) ||
                   (in_data.address < sbmc_pkg::SIDE_HI && rs_eff[3:2] == 2'b01) ||
                   (in_overlay && ac_eff[3]) ||
                   io_hole;

        op.act           = sbmc_pkg::ACT_NONE;
        op.store         = mapped.store;
        op.idx           = mapped.idx;
        op.data          = in_data.data_byte;
        op.write_ignored = 1'b0;
        op.window_strobe = 1'b0;
        op.window_reg    = 3'd0;
        if (!in_data.func)
        begin
            if (modelled && !io_hole)
            begin
                op.act = sbmc_pkg::ACT_CHECK;
            end
        end
        else if (modelled)
        begin
            if (writable)
            begin
                op.act = sbmc_pkg::ACT_STORE;
            end
            else
            begin
                op.write_ignored = 1'b1;
            end
        end
        if (window_enable && in_data.address >= sbmc_pkg::WIN_LO &&
            in_data.address <= sbmc_pkg::WIN_HI)
        begin
            op.window_strobe = 1'b1;
            op.window_reg    = in_data.address[2:0];
        end

        rom_select_next     = rom_select_reg;
        access_control_next = access_control_reg;
        vdu_flag_next       = vdu_flag_reg;
        if (push)
        begin
            rom_select_next     = rs_eff;
            access_control_next = ac_eff;
            vdu_flag_next       = vdu_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_select_reg     <= '0;
            access_control_reg <= '0;
            vdu_flag_reg       <= 1'b0;
        end
        else
        begin
            rom_select_reg     <= rom_select_next;
            access_control_reg <= access_control_next;
            vdu_flag_reg       <= vdu_flag_next;
        end
    end

endmodule

>>> hw/rtl/sbmc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmc_fifo
// Short request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sbmc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sbmc_pkg::op_t din,
    input  logic          pop,
    output sbmc_pkg::op_t dout,
    output logic          full,
    output logic          empty
);

    sbmc_pkg::op_t                     entry_reg [sbmc_pkg::QUEUE_DEPTH];
    logic [sbmc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [sbmc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_next;
    logic [sbmc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [sbmc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_next;
    logic [sbmc_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [sbmc_pkg::QUEUE_CNT_W-1:0]  count_next;

    assign dout  = entry_reg[rd_ptr_reg];
    assign full  = count_reg == sbmc_pkg::QUEUE_CNT_W'(sbmc_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> hw/rtl/sbmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmc_back
// Holds the shadow stores, clears them after reset, and carries out each
// request: read-compare-store for modelled reads, store for modelled writable writes.
// ----------------------------------------------------------------------------
module sbmc_back #(
    parameter int ROM_BANKS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  sbmc_pkg::op_t  q_op,
    output logic           pop,
    output logic           clearing,
    output logic           out_valid,
    input  logic           out_stall,
    output sbmc_pkg::out_t out_data
);

    localparam int BANK_W   = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
    localparam int SW_AW    = BANK_W + sbmc_pkg::BANK_AW;
    localparam int SW_DEPTH = 1 << SW_AW;
    localparam int CLR_W    = (SW_AW > sbmc_pkg::MAIN_AW) ? SW_AW : sbmc_pkg::MAIN_AW;

    logic [sbmc_pkg::CELL_W-1:0] main_mem    [0:sbmc_pkg::MAIN_DEPTH-1];
    logic [sbmc_pkg::CELL_W-1:0] side_mem    [0:SW_DEPTH-1];
    logic [sbmc_pkg::CELL_W-1:0] shadow_mem  [0:sbmc_pkg::SHADOW_DEPTH-1];
    logic [sbmc_pkg::CELL_W-1:0] overlay_mem [0:sbmc_pkg::OVERLAY_DEPTH-1];
    logic [sbmc_pkg::CELL_W-1:0] paged_mem   [0:sbmc_pkg::PAGED_DEPTH-1];

    logic [sbmc_pkg::CELL_W-1:0] main_rd_reg;
    logic [sbmc_pkg::CELL_W-1:0] side_rd_reg;
    logic [sbmc_pkg::CELL_W-1:0] shadow_rd_reg;
    logic [sbmc_pkg::CELL_W-1:0] overlay_rd_reg;
    logic [sbmc_pkg::CELL_W-1:0] paged_rd_reg;

    sbmc_pkg::back_state_t state_reg;
    sbmc_pkg::back_state_t state_next;
    logic [CLR_W-1:0]      clr_reg;
    logic [CLR_W-1:0]      clr_next;
    logic                  fail_reg;
    logic                  fail_next;
    sbmc_pkg::op_t         op_reg;
    sbmc_pkg::op_t         op_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    sbmc_pkg::out_t        out_data_reg;
    sbmc_pkg::out_t        res;

    logic                        out_free;
    logic                        load_out;
    logic                        clear_we;
    logic                        rd_en;
    logic                        wr_en;
    sbmc_pkg::store_t            wr_store;
    logic [sbmc_pkg::IDX_W-1:0]  wr_idx;
    logic [sbmc_pkg::CELL_W-1:0] wr_cell;
    logic [sbmc_pkg::CELL_W-1:0] wd;
    logic [sbmc_pkg::CELL_W-1:0] rd_cell;
    logic                        mis;

    logic                           main_we;
    logic                           side_we;
    logic                           shadow_we;
    logic                           overlay_we;
    logic                           paged_we;
    logic [sbmc_pkg::MAIN_AW-1:0]   main_wa;
    logic [SW_AW-1:0]               side_wa;
    logic [sbmc_pkg::SHADOW_AW-1:0] shadow_wa;
    logic [sbmc_pkg::OVERLAY_AW-1:0] overlay_wa;
    logic [sbmc_pkg::PAGED_AW-1:0]  paged_wa;

    assign out_free  = ~out_valid_reg | ~out_stall;
    assign clearing  = state_reg == sbmc_pkg::ST_CLEAR;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        fail_next  = fail_reg;
        op_next    = op_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        clear_we   = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_store   = q_op.store;
        wr_idx     = q_op.idx;
        wr_cell    = {1'b1, q_op.data};
        mis        = 1'b0;

        unique case (op_reg.store)
            sbmc_pkg::STORE_SIDE:    rd_cell = side_rd_reg;
            sbmc_pkg::STORE_SHADOW:  rd_cell = shadow_rd_reg;
            sbmc_pkg::STORE_OVERLAY: rd_cell = overlay_rd_reg;
            sbmc_pkg::STORE_PAGED:   rd_cell = paged_rd_reg;
            default:                 rd_cell = main_rd_reg;
        endcase

        res.mismatch      = 1'b0;
        res.expected_byte = 8'd0;
        res.write_ignored = q_op.write_ignored;
        res.window_strobe = q_op.window_strobe;
        res.window_reg    = q_op.window_reg;
        res.fail_seen     = fail_reg;

        unique case (state_reg)
            sbmc_pkg::ST_CLEAR:
            begin
                clear_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = sbmc_pkg::ST_IDLE;
                end
            end
            sbmc_pkg::ST_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    pop = 1'b1;
                    if (q_op.act == sbmc_pkg::ACT_CHECK)
                    begin
                        rd_en      = 1'b1;
                        op_next    = q_op;
                        state_next = sbmc_pkg::ST_CHECK;
                    end
                    else
                    begin
                        wr_en    = q_op.act == sbmc_pkg::ACT_STORE;
                        load_out = 1'b1;
                    end
                end
            end
            sbmc_pkg::ST_CHECK:
            begin
                if (out_free)
                begin
                    // unknown cell: no compare, expected reads as zero
                    mis       = rd_cell[8] && rd_cell[7:0] != op_reg.data;
                    fail_next = fail_reg | mis;
                    wr_en     = 1'b1;
                    wr_store  = op_reg.store;
                    wr_idx    = op_reg.idx;
                    wr_cell   = {1'b1, op_reg.data};
                    load_out  = 1'b1;
                    res.mismatch      = mis;
                    res.expected_byte = rd_cell[8] ? rd_cell[7:0] : 8'd0;
                    res.write_ignored = op_reg.write_ignored;
                    res.window_strobe = op_reg.window_strobe;
                    res.window_reg    = op_reg.window_reg;
                    res.fail_seen     = fail_next;
                    state_next        = sbmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbmc_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = load_out | (out_valid_reg & out_stall);
    end

    // one write port per store, shared by the clearing sweep and requests
    always_comb
    begin
        wd         = clear_we ? '0 : wr_cell;
        main_we    = clear_we | (wr_en && wr_store == sbmc_pkg::STORE_MAIN);
        side_we    = clear_we | (wr_en && wr_store == sbmc_pkg::STORE_SIDE);
        shadow_we  = (clear_we && clr_reg[sbmc_pkg::SHADOW_AW-1:0] <
                      sbmc_pkg::SHADOW_AW'(sbmc_pkg::SHADOW_DEPTH)) |
                     (wr_en && wr_store == sbmc_pkg::STORE_SHADOW);
        overlay_we = clear_we | (wr_en && wr_store == sbmc_pkg::STORE_OVERLAY);
        paged_we   = clear_we | (wr_en && wr_store == sbmc_pkg::STORE_PAGED);
        main_wa    = clear_we ? clr_reg[sbmc_pkg::MAIN_AW-1:0] :
                                wr_idx[sbmc_pkg::MAIN_AW-1:0];
        side_wa    = clear_we ? clr_reg[SW_AW-1:0] : wr_idx[SW_AW-1:0];
        shadow_wa  = clear_we ? clr_reg[sbmc_pkg::SHADOW_AW-1:0] :
                                wr_idx[sbmc_pkg::SHADOW_AW-1:0];
        overlay_wa = clear_we ? clr_reg[sbmc_pkg::OVERLAY_AW-1:0] :
                                wr_idx[sbmc_pkg::OVERLAY_AW-1:0];
        paged_wa   = clear_we ? clr_reg[sbmc_pkg::PAGED_AW-1:0] :
                                wr_idx[sbmc_pkg::PAGED_AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (main_we)
        begin
            main_mem[main_wa] <= wd;
        end
        if (rd_en && q_op.store == sbmc_pkg::STORE_MAIN)
        begin
            main_rd_reg <= main_mem[q_op.idx[sbmc_pkg::MAIN_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (side_we)
        begin
            side_mem[side_wa] <= wd;
        end
        if (rd_en && q_op.store == sbmc_pkg::STORE_SIDE)
        begin
            side_rd_reg <= side_mem[q_op.idx[SW_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shadow_we)
        begin
            shadow_mem[shadow_wa] <= wd;
        end
        if (rd_en && q_op.store == sbmc_pkg::STORE_SHADOW)
        begin
            shadow_rd_reg <= shadow_mem[q_op.idx[sbmc_pkg::SHADOW_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (overlay_we)
        begin
            overlay_mem[overlay_wa] <= wd;
        end
        if (rd_en && q_op.store == sbmc_pkg::STORE_OVERLAY)
        begin
            overlay_rd_reg <= overlay_mem[q_op.idx[sbmc_pkg::OVERLAY_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (paged_we)
        begin
            paged_mem[paged_wa] <= wd;
        end
        if (rd_en && q_op.store == sbmc_pkg::STORE_PAGED)
        begin
            paged_rd_reg <= paged_mem[q_op.idx[sbmc_pkg::PAGED_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbmc_pkg::ST_CLEAR;
            clr_reg       <= '0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        if (load_out)
        begin
            out_data_reg <= res;
        end
    end

endmodule

>>> hw/rtl/shadowed_banked_memory_checker.sv
`timescale 1ns / 1ps
// An accepted request waits in the queue until the back end takes it, and its result is
// registered; a modelled read first does a store read, then compare and write back.
// Throughput: 1 request per cycle for writes and unmodelled reads when not stalled;
// a modelled read blocks the next request until its cell is written back.
// Reset: after rst_n the stores are cleared by a sweep of the clear counter over every
// index; in_stall stays high meanwhile, register writes still work.
// ----------------------------------------------------------------------------
// shadowed_banked_memory_checker
// Watches bus accesses, keeps shadow copies of the banked memories and
// flags read mismatches, ignored writes and coprocessor window accesses.
// ----------------------------------------------------------------------------
module shadowed_banked_memory_checker #(
    parameter int ROM_BANKS = 16
) (
    input  logic           clk,
    input  logic           rst_n,

    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,

    input  logic           in_valid,
    output logic           in_stall,
    input  sbmc_pkg::in_t  in_data,

    output logic           out_valid,
    input  logic           out_stall,
    output sbmc_pkg::out_t out_data
);

    logic [7:0]    model_mask_reg;
    logic [7:0]    model_mask_next;
    logic          window_enable_reg;
    logic          window_enable_next;
    logic          cfg_we;

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic          clearing;
    sbmc_pkg::op_t front_op;
    sbmc_pkg::op_t q_op;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_comb
    begin
        model_mask_next    = model_mask_reg;
        window_enable_next = window_enable_reg;
        unique case (sbmc_pkg::reg_idx_t'(paddr[2]))
            sbmc_pkg::REG_MODEL_MASK:
            begin
                prdata = {24'd0, model_mask_reg};
                if (cfg_we)
                begin
                    model_mask_next = pwdata[7:0];
                end
            end
            sbmc_pkg::REG_WINDOW_EN:
            begin
                prdata = {31'd0, window_enable_reg};
                if (cfg_we)
                begin
                    window_enable_next = pwdata[0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_mask_reg    <= '0;
            window_enable_reg <= 1'b0;
        end
        else
        begin
            model_mask_reg    <= model_mask_next;
            window_enable_reg <= window_enable_next;
        end
    end

    sbmc_front #(
        .ROM_BANKS (ROM_BANKS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .model_mask    (model_mask_reg),
        .window_enable (window_enable_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .q_full        (q_full),
        .clearing      (clearing),
        .push          (push),
        .op            (front_op)
    );

    sbmc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_op),
        .pop   (pop),
        .dout  (q_op),
        .full  (q_full),
        .empty (q_empty)
    );

    sbmc_back #(
        .ROM_BANKS (ROM_BANKS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_op      (q_op),
        .pop       (pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/sbmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmc_checker
// Port-level checks on the result channel of the memory checker.
// ----------------------------------------------------------------------------
module sbmc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input sbmc_pkg::out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    a_fail_covers_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_data.mismatch || out_data.fail_seen)
        else $error("mismatch without fail flag");

    a_window_reg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.window_strobe |-> out_data.window_reg == 3'd0)
        else $error("window register set without strobe");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.fail_seen) ##1 out_valid
        |-> out_data.fail_seen)
        else $error("fail flag cleared");

endmodule

bind shadowed_banked_memory_checker sbmc_checker u_sbmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> verif/sbmc_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmc_tracker
// Watches the request and result channels of the shadowed banked memory
// checker, keeps its own latches and shadow bytes, predicts each result and
// compares it field by field. Register writes are taken from the config port.
// ----------------------------------------------------------------------------
module sbmc_tracker #(
    parameter int ROM_BANKS = 16
) (
    input  logic           clk,
    input  logic           rst_n,

    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic           pready,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,

    input  logic           in_valid,
    input  logic           in_stall,
    input  sbmc_pkg::in_t  in_data,

    input  logic           out_valid,
    input  logic           out_stall,
    input  sbmc_pkg::out_t out_data,

    output int             fail_count,
    output int             pending
);

    localparam logic [15:0] OVERLAY_HI = 16'hE000;
    localparam int          KEY_SHIFT  = 20;

    logic [7:0]     model_mask;
    logic           window_en;
    logic [7:0]     rom_sel;
    logic [7:0]     acc_ctl;
    logic           vdu_flag;
    logic           fail_sticky;
    // a key present here means the shadow byte is known
    logic [7:0]     known_cells [int];
    sbmc_pkg::out_t bus_verdicts [$];

    function automatic int cell_key(logic [15:0] a);
        int bank;
        if (acc_ctl[3] && a >= sbmc_pkg::SIDE_HI && a < OVERLAY_HI)
        begin
            return (int'(sbmc_pkg::STORE_OVERLAY) << KEY_SHIFT) | int'(a[12:0]);
        end
        if (rom_sel[7] && a >= sbmc_pkg::SHADOW_HI && a < sbmc_pkg::PAGED_HI)
        begin
            return (int'(sbmc_pkg::STORE_PAGED) << KEY_SHIFT) | int'(a[11:0]);
        end
        if (a >= sbmc_pkg::SHADOW_LO && a < sbmc_pkg::SHADOW_HI &&
            (vdu_flag ? acc_ctl[1] : acc_ctl[2]))
        begin
            return (int'(sbmc_pkg::STORE_SHADOW) << KEY_SHIFT) |
                   int'(a - sbmc_pkg::SHADOW_LO);
        end
        if (a >= sbmc_pkg::SHADOW_HI && a < sbmc_pkg::SIDE_HI)
        begin
            bank = int'(rom_sel[3:0]) % ROM_BANKS;
            return (int'(sbmc_pkg::STORE_SIDE) << KEY_SHIFT) |
                   ((bank << sbmc_pkg::BANK_AW) + int'(a[13:0]));
        end
        return (int'(sbmc_pkg::STORE_MAIN) << KEY_SHIFT) | int'(a);
    endfunction

    function automatic sbmc_pkg::out_t judge_access(sbmc_pkg::in_t req);
        sbmc_pkg::out_t res;
        int             key;
        logic           modelled;
        logic [15:0]    a;
        res = '0;
        a = req.address;
        modelled = model_mask[req.access_kind];
        if (!req.func)
        begin
            if (req.is_fetch)
            begin
                vdu_flag = !acc_ctl[3] && a >= sbmc_pkg::SIDE_HI && a < OVERLAY_HI;
            end
            if (modelled && (a < sbmc_pkg::IO_LO || a >= sbmc_pkg::IO_HI))
            begin
                key = cell_key(a);
                if (known_cells.exists(key))
                begin
                    res.expected_byte = known_cells[key];
                    if (known_cells[key] != req.data_byte)
                    begin
                        res.mismatch = 1'b1;
                        fail_sticky = 1'b1;
                    end
                end
                known_cells[key] = req.data_byte;
            end
        end
        else if (modelled)
        begin
            // latches load first, writability follows the new values
            if (a == sbmc_pkg::ADDR_ROM_LATCH)
            begin
                rom_sel = req.data_byte & sbmc_pkg::ROM_LATCH_MASK;
            end
            if (a == sbmc_pkg::ADDR_ACC_LATCH)
            begin
                acc_ctl = req.data_byte;
            end
            if (a < sbmc_pkg::SHADOW_HI || (a < sbmc_pkg::PAGED_HI && rom_sel[7]) ||
                (a < sbmc_pkg::SIDE_HI && rom_sel[3:2] == 2'b01) ||
                (a >= sbmc_pkg::SIDE_HI && a < OVERLAY_HI && acc_ctl[3]) ||
                (a >= sbmc_pkg::IO_LO && a < sbmc_pkg::IO_HI))
            begin
                known_cells[cell_key(a)] = req.data_byte;
            end
            else
            begin
                res.write_ignored = 1'b1;
            end
        end
        if (window_en && a >= sbmc_pkg::WIN_LO && a <= sbmc_pkg::WIN_HI)
        begin
            res.window_strobe = 1'b1;
            res.window_reg = a[2:0];
        end
        res.fail_seen = fail_sticky;
        return res;
    endfunction

    task automatic report(string msg);
        $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare(sbmc_pkg::out_t got, sbmc_pkg::out_t want);
        if (got.mismatch !== want.mismatch)
        begin
            report($sformatf("mismatch flag %b, predicted %b", got.mismatch, want.mismatch));
        end
        if (got.expected_byte !== want.expected_byte)
        begin
            report($sformatf("expected_byte %h, predicted %h",
                             got.expected_byte, want.expected_byte));
        end
        if (got.write_ignored !== want.write_ignored)
        begin
            report($sformatf("write_ignored %b, predicted %b",
                             got.write_ignored, want.write_ignored));
        end
        if (got.window_strobe !== want.window_strobe)
        begin
            report($sformatf("window_strobe %b, predicted %b",
                             got.window_strobe, want.window_strobe));
        end
        if (got.window_reg !== want.window_reg)
        begin
            report($sformatf("window_reg %0d, predicted %0d", got.window_reg, want.window_reg));
        end
        if (got.fail_seen !== want.fail_seen)
        begin
            report($sformatf("fail_seen %b, predicted %b", got.fail_seen, want.fail_seen));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_mask  = '0;
            window_en   = 1'b0;
            rom_sel     = '0;
            acc_ctl     = '0;
            vdu_flag    = 1'b0;
            fail_sticky = 1'b0;
            known_cells.delete();
            bus_verdicts.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                unique case (sbmc_pkg::reg_idx_t'(paddr[2]))
                    sbmc_pkg::REG_MODEL_MASK: model_mask = pwdata[7:0];
                    sbmc_pkg::REG_WINDOW_EN:  window_en  = pwdata[0];
                endcase
            end
            if (in_valid && !in_stall)
            begin
                bus_verdicts.push_back(judge_access(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (bus_verdicts.size() == 0)
                begin
                    report($sformatf("result with no request pending: %p", out_data));
                end
                else
                begin
                    compare(out_data, bus_verdicts.pop_front());
                end
            end
        end
        pending = bus_verdicts.size();
    end

endmodule

>>> verif/tb_shadowed_banked_memory_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shadowed_banked_memory_checker
// Drives bus accesses into the shadowed banked memory checker: a directed run
// over the address map and special cases, then random traffic under several
// register settings, with random stalls, a long result-side hold and drains.
// ----------------------------------------------------------------------------
module tb_shadowed_banked_memory_checker;

    localparam logic FUNC_READ   = 1'b0;
    localparam logic FUNC_WRITE  = 1'b1;
    localparam int   LONG_HOLD   = 300;
    localparam int   PHASE_ITEMS = 260;
    localparam int   POOL_SIZE   = 64;

    logic           clk;
    logic           rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;
    logic           in_valid;
    logic           in_stall;
    sbmc_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    sbmc_pkg::out_t out_data;

    int             fail_count;
    int             pending;
    bit             hold_req;
    bit             hold_seen;
    // recently used addresses, so reads often land on known bytes
    logic [15:0]    pool_addr [POOL_SIZE];
    logic [7:0]     pool_data [POOL_SIZE];

    shadowed_banked_memory_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    sbmc_tracker tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int idle_len();
        return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3)) :
                                            int'($urandom_range(10, 40));
    endfunction

    function automatic int pick_gap();
        return $urandom_range(0, 1) ? 0 : idle_len();
    endfunction

    function automatic sbmc_pkg::in_t bus_op(logic func, logic [15:0] a, logic [7:0] d,
                                             logic [2:0] kind, logic fetch);
        sbmc_pkg::in_t r;
        r.func        = func;
        r.address     = a;
        r.data_byte   = d;
        r.access_kind = kind;
        r.is_fetch    = fetch;
        return r;
    endfunction

    function automatic sbmc_pkg::in_t random_access();
        sbmc_pkg::in_t r;
        int            slot;
        bit            from_pool;
        r.func        = ($urandom_range(0, 9) < 4) ? FUNC_WRITE : FUNC_READ;
        r.data_byte   = 8'($urandom_range(0, 255));
        r.access_kind = 3'($urandom_range(0, 7));
        r.is_fetch    = ($urandom_range(0, 3) == 0);
        slot          = int'($urandom_range(0, POOL_SIZE - 1));
        from_pool     = 1'b0;
        case ($urandom_range(0, 11))
            0, 1, 2, 3:
            begin
                from_pool = 1'b1;
                r.address = pool_addr[slot];
                if (r.func == FUNC_READ && $urandom_range(0, 3) != 0)
                begin
                    r.data_byte = pool_data[slot];
                end
            end
            4:  r.address = 16'($urandom_range(0, 16'h2FFF));
            5:  r.address = 16'($urandom_range(16'h3000, 16'h7FFF));
            6:  r.address = 16'($urandom_range(16'h8000, 16'h8FFF));
            7:  r.address = 16'($urandom_range(16'h9000, 16'hBFFF));
            8:  r.address = 16'($urandom_range(16'hC000, 16'hDFFF));
            9:  r.address = 16'($urandom_range(16'hE000, 16'hFFFF));
            10:
            begin
                case ($urandom_range(0, 3))
                    0:       r.address = sbmc_pkg::ADDR_ROM_LATCH;
                    1:       r.address = sbmc_pkg::ADDR_ACC_LATCH;
                    2:       r.address = 16'($urandom_range(sbmc_pkg::WIN_LO - 1,
                                                            sbmc_pkg::WIN_HI + 1));
                    default: r.address = 16'($urandom_range(sbmc_pkg::IO_LO,
                                                            sbmc_pkg::IO_HI - 1));
                endcase
            end
            default: r.address = 16'($urandom_range(0, 16'hFFFF));
        endcase
        if (from_pool || $urandom_range(0, 1))
        begin
            pool_addr[slot] = r.address;
            pool_data[slot] = r.data_byte;
        end
        return r;
    endfunction

    task automatic reg_write(sbmc_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send(sbmc_pkg::in_t r);
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic burst(int count, bit gaps);
        int gap;
        repeat (count)
        begin
            send(random_access());
            gap = gaps ? pick_gap() : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] phase_mask [7];
        bit         phase_win  [7];
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        in_data  <= '0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_addr[i] = 16'($urandom_range(0, 16'hFFFF));
            pool_data[i] = 8'($urandom_range(0, 255));
        end
        phase_mask = '{8'hFF, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'hFF};
        phase_win  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_mask[5] = 8'($urandom_range(0, 255));
        phase_win[5]  = 1'($urandom_range(0, 1));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // kind 7 left unmodelled for the directed run
        reg_write(sbmc_pkg::REG_MODEL_MASK, 32'h7F);
        reg_write(sbmc_pkg::REG_WINDOW_EN, 32'h1);
        send(bus_op(FUNC_WRITE, 16'h0000, 8'h00, 3'd0, 1'b0));
        send(bus_op(FUNC_READ,  16'h0000, 8'h00, 3'd1, 1'b0));
        send(bus_op(FUNC_READ,  16'h0000, 8'hFF, 3'd6, 1'b0));
        send(bus_op(FUNC_READ,  16'hFFFF, 8'hAA, 3'd2, 1'b1));
        send(bus_op(FUNC_READ,  16'hFC00, 8'h12, 3'd3, 1'b0));
        send(bus_op(FUNC_WRITE, 16'hFEFF, 8'h34, 3'd4, 1'b0));
        send(bus_op(FUNC_READ,  16'hFEFF, 8'h35, 3'd5, 1'b0));
        // paged RAM over bank 15, then bank 4 writable, then bank 0 read-only
        send(bus_op(FUNC_WRITE, sbmc_pkg::ADDR_ROM_LATCH, 8'hFF, 3'd0, 1'b0));
        send(bus_op(FUNC_WRITE, 16'h8000, 8'h11, 3'd1, 1'b0));
        send(bus_op(FUNC_WRITE, 16'h9000, 8'h22, 3'd2, 1'b0));
        send(bus_op(FUNC_READ,  16'h8000, 8'h11, 3'd3, 1'b0));
        send(bus_op(FUNC_WRITE, sbmc_pkg::ADDR_ROM_LATCH, 8'h04, 3'd0, 1'b0));
        send(bus_op(FUNC_WRITE, 16'hBFFF, 8'h44, 3'd1, 1'b0));
        send(bus_op(FUNC_WRITE, sbmc_pkg::ADDR_ROM_LATCH, 8'h00, 3'd0, 1'b0));
        send(bus_op(FUNC_WRITE, 16'h8000, 8'h55, 3'd1, 1'b0));
        // overlay RAM on, then shadow RAM selected through the video flag
        send(bus_op(FUNC_WRITE, sbmc_pkg::ADDR_ACC_LATCH, 8'h08, 3'd2, 1'b0));
        send(bus_op(FUNC_WRITE, 16'hC000, 8'h66, 3'd3, 1'b0));
        send(bus_op(FUNC_READ,  16'hC000, 8'h67, 3'd4, 1'b1));
        send(bus_op(FUNC_WRITE, 16'hE000, 8'h77, 3'd5, 1'b0));
        send(bus_op(FUNC_WRITE, sbmc_pkg::ADDR_ACC_LATCH, 8'h02, 3'd6, 1'b0));
        send(bus_op(FUNC_READ,  16'hC123, 8'h88, 3'd7, 1'b1));
        send(bus_op(FUNC_WRITE, 16'h3000, 8'h99, 3'd0, 1'b1));
        send(bus_op(FUNC_READ,  16'h7FFF, 8'h01, 3'd1, 1'b0));
        send(bus_op(FUNC_READ,  sbmc_pkg::WIN_LO, 8'h00, 3'd7, 1'b0));
        send(bus_op(FUNC_WRITE, sbmc_pkg::WIN_HI, 8'hFF, 3'd7, 1'b0));
        send(bus_op(FUNC_READ,  16'hFEE7, 8'h5A, 3'd2, 1'b0));
        drain();

        for (int p = 0; p < 7; p++)
        begin
            reg_write(sbmc_pkg::REG_MODEL_MASK, {24'h0, phase_mask[p]});
            reg_write(sbmc_pkg::REG_WINDOW_EN, {31'h0, phase_win[p]});
            burst(PHASE_ITEMS, $urandom_range(0, 3) != 0);
            if (p == 2)
            begin
                // park the result side and keep offering requests so the block backs up
                drain();
                hold_req = 1'b1;
                wait (hold_seen);
                @(posedge clk);
                burst(40, 1'b0);
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin : result_side
        forever
        begin
            if (hold_req && !hold_seen)
            begin
                hold_seen = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (idle_len()) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        #24_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
